### rtl/pvp_pkg.sv
// Shared types and constants for the axis position/velocity profiler.
// No dependencies; the RTL files refer to it by scoped names, the testbench files import it.
package pvp_pkg;

    // Field and register widths
    localparam int POS_W   = 32;
    localparam int SPEED_W = 21;
    localparam int MOTOR_W = 25;
    localparam int CFG_W   = 21;
    localparam int ERR_W   = 33;
    localparam int QUOT_W  = 22;
    localparam int RECIP_W = 23;

    // Q16.16 profile constants
    localparam logic [ERR_W-1:0]   SETTLE_BAND = 33'd3277;
    localparam logic [ERR_W-1:0]   DECEL_RANGE = 33'd786432;
    localparam logic [SPEED_W-1:0] SPEED_FLOOR = 21'd11796;
    localparam logic [SPEED_W-1:0] SLEW_STEP   = 21'd3277;
    localparam logic [SPEED_W-1:0] SPEED_MAX   = 21'd1048576;

    // ceil(2^24 / 3): exact floor(q / 3) for q below 2^23
    localparam logic [RECIP_W-1:0] RECIP3       = 23'd5592406;
    localparam int                 RECIP3_SHIFT = 24;

    // Reset values of the configuration registers
    localparam logic [CFG_W-1:0] SPEED_LIMIT_RST = 21'd65536;
    localparam logic [CFG_W-1:0] ARRIVE_TOL_RST  = 21'd78643;

    // Configuration register indexes
    localparam logic CFG_SPEED_LIMIT = 1'b0;
    localparam logic CFG_ARRIVE_TOL  = 1'b1;

    // Request kinds
    typedef enum logic [1:0] {
        KIND_TICK   = 2'd0,
        KIND_TARGET = 2'd1,
        KIND_START  = 2'd2,
        KIND_STOP   = 2'd3
    } kind_t;

    // Error stage result handed to the control stage
    typedef struct packed {
        kind_t                   kind;
        logic signed [POS_W-1:0] setpoint;
        logic                    settle;
        logic                    full;
        logic                    in_band;
        logic [QUOT_W-1:0]       quot_pre;
    } mid_t;

endpackage

### rtl/pvp_in_if.sv
// Request channel of the profiler: valid/ready handshake with the item fields.
// Depends on pvp_pkg for the field widths.
interface pvp_in_if;
    logic                             valid;
    logic                             ready;
    logic [1:0]                       kind;
    logic signed [pvp_pkg::POS_W-1:0] position_sample;
    logic signed [pvp_pkg::POS_W-1:0] new_target;

    modport source (output valid, output kind, output position_sample,
                    output new_target, input ready);
    modport sink   (input valid, input kind, input position_sample,
                    input new_target, output ready);
endinterface

### rtl/pvp_out_if.sv
// Result channel of the profiler: valid/ready handshake with the result fields.
// Depends on pvp_pkg for the field widths.
interface pvp_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [pvp_pkg::POS_W-1:0] position_setpoint;
    logic [pvp_pkg::MOTOR_W-1:0]      motor_speed;
    logic                             command_sent;
    logic                             busy_flag;
    logic                             arrived_flag;

    modport source (output valid, output position_setpoint, output motor_speed,
                    output command_sent, output busy_flag, output arrived_flag,
                    input ready);
    modport sink   (input valid, input position_setpoint, input motor_speed,
                    input command_sent, input busy_flag, input arrived_flag,
                    output ready);
endinterface

### rtl/pvp_error_stage.sv
// Input register, goal position and position-error front end of the profiler.
// Depends on pvp_pkg and pvp_in_if.
module pvp_error_stage
(
    input  logic                          clk,
    input  logic                          rst_n,
    pvp_in_if.sink                        item,
    input  logic [pvp_pkg::SPEED_W-1:0]   lim,
    input  logic [pvp_pkg::CFG_W-1:0]     arrive_tol,
    output logic                          mid_valid,
    input  logic                          mid_ready,
    output pvp_pkg::mid_t                 mid
);

    logic                             in_valid_reg;
    pvp_pkg::kind_t                   kind_reg;
    logic signed [pvp_pkg::POS_W-1:0] pos_reg;
    logic signed [pvp_pkg::POS_W-1:0] target_reg;
    logic signed [pvp_pkg::POS_W-1:0] goal_reg;
    logic signed [pvp_pkg::POS_W-1:0] goal_next;

    logic                             s1_go;
    logic signed [pvp_pkg::ERR_W-1:0] diff;
    logic [pvp_pkg::ERR_W-1:0]        err_abs;
    logic [19:0]                      err_mid;
    logic [40:0]                      prod;

    // Take a new request whenever the register is empty or moving on
    assign s1_go      = in_valid_reg && mid_ready;
    assign item.ready = !in_valid_reg || mid_ready;
    assign mid_valid  = in_valid_reg;

    // Hold the request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (item.ready)
        begin
            in_valid_reg <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            kind_reg   <= pvp_pkg::kind_t'(item.kind);
            pos_reg    <= item.position_sample;
            target_reg <= item.new_target;
        end
    end

    // Advance the goal in request order
    assign goal_next = (kind_reg == pvp_pkg::KIND_TARGET) ? target_reg : goal_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            goal_reg <= '0;
        end
        else if (s1_go)
        begin
            goal_reg <= goal_next;
        end
    end

    // Absolute error against the current goal
    always_comb
    begin
        diff    = {goal_reg[pvp_pkg::POS_W-1], goal_reg} - {pos_reg[pvp_pkg::POS_W-1], pos_reg};
        err_abs = diff[pvp_pkg::ERR_W-1] ? pvp_pkg::ERR_W'(-diff) : pvp_pkg::ERR_W'(diff);
        // Only the band below the deceleration range uses the product
        err_mid = err_abs[19:0];
        prod    = {20'd0, lim} * {21'd0, err_mid};
    end

    // Build the stage result; saturate negation of the most negative goal
    always_comb
    begin
        mid.kind     = kind_reg;
        mid.setpoint = (goal_next == {1'b1, {(pvp_pkg::POS_W-1){1'b0}}})
                     ? {1'b0, {(pvp_pkg::POS_W-1){1'b1}}}
                     : -goal_next;
        mid.settle   = err_abs <= pvp_pkg::SETTLE_BAND;
        mid.full     = err_abs >= pvp_pkg::DECEL_RANGE;
        mid.in_band  = err_abs <= {{(pvp_pkg::ERR_W-pvp_pkg::CFG_W){1'b0}}, arrive_tol};
        mid.quot_pre = prod[39:18];
    end

endmodule

### rtl/pvp_ctrl_stage.sv
// Speed slew, period/hold counters, busy/arrived flags and result register.
// Depends on pvp_pkg and pvp_out_if.
module pvp_ctrl_stage
#(
    parameter int UPDATE_PERIOD_MS = 10,
    parameter int ARRIVE_HOLD_MS   = 80
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          mid_valid,
    output logic                          mid_ready,
    input  pvp_pkg::mid_t                 mid,
    input  logic [pvp_pkg::SPEED_W-1:0]   lim,
    pvp_out_if.source                     result
);

    localparam int PC_W = $clog2(UPDATE_PERIOD_MS + 1);
    localparam int HC_W = $clog2(ARRIVE_HOLD_MS + 1);
    localparam logic [PC_W-1:0] PERIOD = PC_W'(UPDATE_PERIOD_MS);
    localparam logic [HC_W-1:0] HOLD   = HC_W'(ARRIVE_HOLD_MS);
    localparam int PROD_W = pvp_pkg::QUOT_W + pvp_pkg::RECIP_W;

    logic                           s2_valid_reg;
    pvp_pkg::mid_t                  m_reg;
    logic                           s2_go;

    logic                           run_reg, run_next;
    logic                           moving_reg, moving_next;
    logic                           at_target_reg, at_target_next;
    logic [pvp_pkg::SPEED_W-1:0]    speed_reg, speed_next;
    logic [PC_W-1:0]                pc_reg, pc_next, pc_inc;
    logic [HC_W-1:0]                hc_reg, hc_next, hc_inc;
    logic                           sent;

    logic [PROD_W-1:0]              prod3;
    logic [pvp_pkg::SPEED_W-1:0]    quot;
    logic [pvp_pkg::SPEED_W-1:0]    tgt_mid;
    logic [pvp_pkg::SPEED_W-1:0]    tgt;
    logic [pvp_pkg::SPEED_W-1:0]    slewed;
    logic [pvp_pkg::MOTOR_W:0]      speed_x30;

    logic                           out_valid_reg;

    // Move on when the result register is free or being emptied
    assign s2_go     = s2_valid_reg && (!out_valid_reg || result.ready);
    assign mid_ready = !s2_valid_reg || s2_go;

    // Hold the error stage result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (mid_ready)
        begin
            s2_valid_reg <= mid_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mid_valid && mid_ready)
        begin
            m_reg <= mid;
        end
    end

    // Speed target: divide the scaled error by three, then floor and clamp; zero when settled, the limit at full range
    always_comb
    begin
        prod3   = {{pvp_pkg::RECIP_W{1'b0}}, m_reg.quot_pre} *
                  {{pvp_pkg::QUOT_W{1'b0}}, pvp_pkg::RECIP3};
        quot    = prod3[pvp_pkg::RECIP3_SHIFT +: pvp_pkg::SPEED_W];
        if (quot < pvp_pkg::SPEED_FLOOR)
        begin
            tgt_mid = pvp_pkg::SPEED_FLOOR;
        end
        else if (quot > lim)
        begin
            tgt_mid = lim;
        end
        else
        begin
            tgt_mid = quot;
        end
        if (m_reg.settle)
        begin
            tgt = '0;
        end
        else if (m_reg.full)
        begin
            tgt = lim;
        end
        else
        begin
            tgt = tgt_mid;
        end
    end

    // Slew the commanded speed toward the target
    always_comb
    begin
        if (tgt > speed_reg)
        begin
            slewed = (tgt - speed_reg > pvp_pkg::SLEW_STEP)
                   ? speed_reg + pvp_pkg::SLEW_STEP : tgt;
        end
        else
        begin
            slewed = (speed_reg - tgt > pvp_pkg::SLEW_STEP)
                   ? speed_reg - pvp_pkg::SLEW_STEP : tgt;
        end
    end

    // Next state for the request in this stage
    always_comb
    begin
        pc_inc         = (pc_reg < PERIOD) ? pc_reg + PC_W'(1) : pc_reg;
        hc_inc         = (hc_reg < HOLD) ? hc_reg + HC_W'(1) : hc_reg;
        run_next       = run_reg;
        moving_next    = moving_reg;
        at_target_next = at_target_reg;
        speed_next     = speed_reg;
        pc_next        = pc_reg;
        hc_next        = hc_reg;
        sent           = 1'b0;
        case (m_reg.kind)
            pvp_pkg::KIND_TICK:
            begin
                pc_next = pc_inc;
                hc_next = hc_inc;
                if (run_reg)
                begin
                    if (pc_inc >= PERIOD)
                    begin
                        pc_next    = '0;
                        speed_next = slewed;
                        sent       = 1'b1;
                    end
                    if (m_reg.in_band)
                    begin
                        if (hc_inc >= HOLD)
                        begin
                            moving_next    = 1'b0;
                            at_target_next = 1'b1;
                        end
                    end
                    else
                    begin
                        moving_next    = 1'b1;
                        at_target_next = 1'b0;
                        hc_next        = '0;
                    end
                end
            end
            pvp_pkg::KIND_TARGET:
            begin
                moving_next    = 1'b1;
                at_target_next = 1'b0;
                hc_next        = '0;
            end
            pvp_pkg::KIND_START:
            begin
                run_next       = 1'b1;
                moving_next    = 1'b1;
                at_target_next = 1'b0;
                hc_next        = '0;
            end
            pvp_pkg::KIND_STOP:
            begin
                run_next       = 1'b0;
                moving_next    = 1'b0;
                at_target_next = 1'b1;
                speed_next     = '0;
            end
            default:
            begin
                run_next = run_reg;
            end
        endcase
    end

    // Scale the speed by thirty as 32x minus 2x
    assign speed_x30 = {speed_next, 5'd0} - {4'd0, speed_next, 1'd0};

    // Update state and the result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg       <= 1'b0;
            moving_reg    <= 1'b0;
            at_target_reg <= 1'b1;
            speed_reg     <= '0;
            pc_reg        <= '0;
            hc_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s2_go)
            begin
                run_reg       <= run_next;
                moving_reg    <= moving_next;
                at_target_reg <= at_target_next;
                speed_reg     <= speed_next;
                pc_reg        <= pc_next;
                hc_reg        <= hc_next;
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Load the result payload
    always_ff @(posedge clk)
    begin
        if (s2_go)
        begin
            result.position_setpoint <= m_reg.setpoint;
            result.motor_speed       <= speed_x30[pvp_pkg::MOTOR_W-1:0];
            result.command_sent      <= sent;
            result.busy_flag         <= run_next && moving_next;
            result.arrived_flag      <= at_target_next;
        end
    end

    assign result.valid = out_valid_reg;

`ifndef SYNTH
    // A control update only happens while the axis is enabled
    a_sent_needs_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && result.command_sent |-> run_reg)
        else $error("command sent while axis disabled");

    // Speed stays zero while disabled
    a_idle_speed_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !run_reg |-> speed_reg == '0)
        else $error("nonzero speed while disabled");

    // Arrival and motion are exclusive
    a_arrive_vs_moving: assert property (@(posedge clk) disable iff (!rst_n)
        at_target_reg != moving_reg)
        else $error("arrived and moving disagree");

    // Speed never exceeds the clamped limit range
    a_speed_range: assert property (@(posedge clk) disable iff (!rst_n)
        speed_reg <= pvp_pkg::SPEED_MAX)
        else $error("speed above maximum");

    // A stalled result leaves the state untouched
    a_stall_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !result.ready |=> $stable(speed_reg) && $stable(pc_reg))
        else $error("state moved during output stall");
`endif

endmodule

### rtl/axis_position_velocity_profiler.sv
// Pipeline: a request accepted into the input register passes on through the
// error/product register and then the result register, where its result is valid.
// Throughput: one request per cycle; the slew loop closes in the control
// stage, and ready stalls only on a held result.
// Reset: configuration returns to speed 1.0 and tolerance 1.2, axis disabled,
// arrived set, goal, speed and counters cleared.
module axis_position_velocity_profiler
#(
    parameter int UPDATE_PERIOD_MS = 10,
    parameter int ARRIVE_HOLD_MS   = 80
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    pvp_in_if.sink                      item,
    pvp_out_if.source                   result,
    input  logic                        cfg_write,
    input  logic                        cfg_index,
    input  logic [pvp_pkg::CFG_W-1:0]   cfg_data
);

    logic [pvp_pkg::CFG_W-1:0]   speed_limit_reg;
    logic [pvp_pkg::CFG_W-1:0]   arrive_tol_reg;
    logic [pvp_pkg::SPEED_W-1:0] lim;
    logic                        mid_valid;
    logic                        mid_ready;
    pvp_pkg::mid_t               mid;

    // Hold the configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_limit_reg <= pvp_pkg::SPEED_LIMIT_RST;
            arrive_tol_reg  <= pvp_pkg::ARRIVE_TOL_RST;
        end
        else if (cfg_write)
        begin
            if (cfg_index == pvp_pkg::CFG_SPEED_LIMIT)
            begin
                speed_limit_reg <= cfg_data;
            end
            if (cfg_index == pvp_pkg::CFG_ARRIVE_TOL)
            begin
                arrive_tol_reg <= cfg_data;
            end
        end
    end

    // Clamp the speed limit to the maximum
    assign lim = (speed_limit_reg > pvp_pkg::SPEED_MAX) ? pvp_pkg::SPEED_MAX
                                                        : speed_limit_reg;

    pvp_error_stage u_error
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .lim        (lim),
        .arrive_tol (arrive_tol_reg),
        .mid_valid  (mid_valid),
        .mid_ready  (mid_ready),
        .mid        (mid)
    );

    pvp_ctrl_stage
    #(
        .UPDATE_PERIOD_MS (UPDATE_PERIOD_MS),
        .ARRIVE_HOLD_MS   (ARRIVE_HOLD_MS)
    )
    u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .mid_valid (mid_valid),
        .mid_ready (mid_ready),
        .mid       (mid),
        .lim       (lim),
        .result    (result)
    );

endmodule

### test/pvp_profile_checker.sv
// Result checker for the axis position/velocity profiler: predicts every result
// from the accepted requests and register writes and compares it field by field.
// Depends on pvp_pkg and the pvp_in_if / pvp_out_if channel interfaces.
module pvp_profile_checker
(
    input  logic                      clk,
    input  logic                      rst_n,
    pvp_in_if                         item,
    pvp_out_if                        result,
    input  logic                      cfg_write,
    input  logic                      cfg_index,
    input  logic [pvp_pkg::CFG_W-1:0] cfg_data,
    output int                        fail_count,
    output int                        outstanding,
    output int                        update_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import pvp_pkg::*;

    localparam int PERIOD_TICKS = 10;
    localparam int HOLD_TICKS   = 80;
    localparam int SPEED_SCALE  = 30;

    typedef struct packed {
        logic signed [POS_W-1:0] setpoint;
        logic [MOTOR_W-1:0]      speed;
        logic                    sent;
        logic                    busy;
        logic                    arrived;
    } report_t;

    // Shadow of the registers and of the axis state
    logic [CFG_W-1:0]        limit_reg;
    logic [CFG_W-1:0]        tol_reg;
    logic                    run_on;
    logic                    in_motion;
    logic                    settled;
    logic signed [POS_W-1:0] goal;
    logic [SPEED_W-1:0]      speed_cmd;
    int unsigned             period_cnt;
    int unsigned             hold_cnt;

    report_t                 expected_reports[$];
    report_t                 want;
    int                      fails = 0;
    int                      updates = 0;

    // Advance the axis state by one request and build the report it yields
    function automatic report_t predict_report(kind_t kind, logic signed [POS_W-1:0] pos,
                                               logic signed [POS_W-1:0] target);
        report_t            rep;
        longint             diff;
        logic [ERR_W-1:0]   err;
        logic [SPEED_W-1:0] lim;
        logic [SPEED_W-1:0] aim;
        logic [63:0]        scaled;

        rep.sent = 1'b0;
        case (kind)
            KIND_TICK:
            begin
                diff = longint'(goal) - longint'(pos);
                err  = (diff < 0) ? ERR_W'(-diff) : ERR_W'(diff);
                if (period_cnt < PERIOD_TICKS)
                    period_cnt++;
                if (hold_cnt < HOLD_TICKS)
                    hold_cnt++;
                if (run_on)
                begin
                    if (period_cnt >= PERIOD_TICKS)
                    begin
                        period_cnt = 0;
                        lim = (limit_reg > SPEED_MAX) ? SPEED_MAX : limit_reg;
                        // speed target: zero in the settle band, full beyond decel range
                        if (err <= SETTLE_BAND)
                            aim = '0;
                        else if (err >= DECEL_RANGE)
                            aim = lim;
                        else
                        begin
                            scaled = (64'(lim) * 64'(err)) / 64'(DECEL_RANGE);
                            aim    = SPEED_W'(scaled);
                            if (aim < SPEED_FLOOR)
                                aim = SPEED_FLOOR;
                            else if (aim > lim)
                                aim = lim;
                        end
                        // slew the command toward the target by one step at most
                        if (aim > speed_cmd)
                            speed_cmd = (aim - speed_cmd > SLEW_STEP) ?
                                        speed_cmd + SLEW_STEP : aim;
                        else
                            speed_cmd = (speed_cmd - aim > SLEW_STEP) ?
                                        speed_cmd - SLEW_STEP : aim;
                        rep.sent = 1'b1;
                    end
                    // arrival needs the full hold inside the tolerance band
                    if (err <= ERR_W'(tol_reg))
                    begin
                        if (hold_cnt >= HOLD_TICKS)
                        begin
                            in_motion = 1'b0;
                            settled   = 1'b1;
                        end
                    end
                    else
                    begin
                        in_motion = 1'b1;
                        settled   = 1'b0;
                        hold_cnt  = 0;
                    end
                end
            end
            KIND_TARGET:
            begin
                goal      = target;
                in_motion = 1'b1;
                settled   = 1'b0;
                hold_cnt  = 0;
            end
            KIND_START:
            begin
                run_on    = 1'b1;
                in_motion = 1'b1;
                settled   = 1'b0;
                hold_cnt  = 0;
            end
            default:
            begin
                run_on    = 1'b0;
                in_motion = 1'b0;
                settled   = 1'b1;
                speed_cmd = '0;
            end
        endcase

        // negation of the most negative goal saturates
        rep.setpoint = (goal == {1'b1, {(POS_W-1){1'b0}}}) ? 32'sh7FFFFFFF : -goal;
        rep.speed    = MOTOR_W'(32'(speed_cmd) * SPEED_SCALE);
        rep.busy     = run_on && in_motion;
        rep.arrived  = settled;
        return rep;
    endfunction

    task automatic check_field(string field, longint expected_val, longint actual_val);
        if (expected_val != actual_val)
        begin
            $error("%s: expected %0d, got %0d", field, expected_val, actual_val);
            fails++;
        end
    endtask

    // Compare results first, then queue the prediction for a new request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg  = SPEED_LIMIT_RST;
            tol_reg    = ARRIVE_TOL_RST;
            run_on     = 1'b0;
            in_motion  = 1'b0;
            settled    = 1'b1;
            goal       = '0;
            speed_cmd  = '0;
            period_cnt = 0;
            hold_cnt   = 0;
            expected_reports.delete();
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                if (expected_reports.size() == 0)
                begin
                    $error("result with no request pending");
                    fails++;
                end
                else
                begin
                    want = expected_reports.pop_front();
                    check_field("position_setpoint", want.setpoint, result.position_setpoint);
                    check_field("motor_speed", want.speed, result.motor_speed);
                    check_field("command_sent", want.sent, result.command_sent);
                    check_field("busy_flag", want.busy, result.busy_flag);
                    check_field("arrived_flag", want.arrived, result.arrived_flag);
                    if (result.command_sent)
                        updates++;
                end
            end
            if (item.valid && item.ready)
                expected_reports.push_back(predict_report(kind_t'(item.kind),
                                                          item.position_sample,
                                                          item.new_target));
            if (cfg_write)
            begin
                if (cfg_index == CFG_SPEED_LIMIT)
                    limit_reg = cfg_data;
                else
                    tol_reg = cfg_data;
            end
        end
        fail_count   <= fails;
        outstanding  <= expected_reports.size();
        update_count <= updates;
    end

endmodule

### test/axis_position_velocity_profiler_test.sv
// Top of the profiler testbench: clock, reset, register settings and request
// stimulus with random idling; verdict from the failure count of the checker.
// Depends on pvp_pkg, the channel interfaces, the profiler and pvp_profile_checker.
module axis_position_velocity_profiler_test;
    timeunit 1ns;
    timeprecision 1ps;
    import pvp_pkg::*;

    localparam int REQUEST_TARGET = 1250;
    localparam int PHASES         = 6;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 8;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_write;
    logic             cfg_index;
    logic [CFG_W-1:0] cfg_data;

    int fail_count;
    int outstanding;
    int update_count;
    int requests_sent = 0;
    int settings_used = 0;
    int quiet_cycles = 0;
    bit steady = 1'b0;

    pvp_in_if  item_ch();
    pvp_out_if result_ch();

    axis_position_velocity_profiler dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_ch),
        .result    (result_ch),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    pvp_profile_checker profile_check
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item_ch),
        .result       (result_ch),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .outstanding  (outstanding),
        .update_count (update_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Idle length: mostly none, some short, a few long; none in steady stretches
    function automatic int pick_gap();
        int roll;

        roll = $urandom_range(0, 99);
        if (steady || roll < 55)
            return 0;
        if (roll < 88)
            return $urandom_range(1, 3);
        if (roll < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Error offset from the goal, weighted toward the profile boundaries
    function automatic longint pick_offset();
        longint mag;

        case ($urandom_range(0, 7))
            0:       mag = 0;
            1:       mag = longint'(SETTLE_BAND);
            2:       mag = longint'(SETTLE_BAND) + 1;
            3:       mag = longint'(DECEL_RANGE) - 1;
            4:       mag = longint'(DECEL_RANGE);
            5:       mag = longint'($urandom());
            6:       mag = longint'($urandom_range(32'(SETTLE_BAND) + 1,
                                                   32'(DECEL_RANGE) - 1));
            default: mag = longint'($urandom_range(0, 100000));
        endcase
        return $urandom_range(0, 1) ? mag : -mag;
    endfunction

    task automatic send_request(kind_t kind, logic signed [POS_W-1:0] pos,
                                logic signed [POS_W-1:0] target);
        int gap;

        gap = pick_gap();
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid           <= 1'b1;
        item_ch.kind            <= kind;
        item_ch.position_sample <= pos;
        item_ch.new_target      <= target;
        do @(posedge clk); while (!item_ch.ready);
        requests_sent++;
    endtask

    task automatic tick(logic signed [POS_W-1:0] pos);
        send_request(KIND_TICK, pos, $urandom());
    endtask

    task automatic set_goal(logic signed [POS_W-1:0] target);
        send_request(KIND_TARGET, $urandom(), target);
    endtask

    task automatic start_axis();
        send_request(KIND_START, $urandom(), $urandom());
    endtask

    task automatic stop_axis();
        send_request(KIND_STOP, $urandom(), $urandom());
    endtask

    // Drop valid and hold until every result is back and the pipeline is empty
    task automatic drain();
        item_ch.valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write both registers back to back while the block is idle
    task automatic apply_setting(logic [CFG_W-1:0] limit, logic [CFG_W-1:0] tol);
        cfg_write <= 1'b1;
        cfg_index <= CFG_SPEED_LIMIT;
        cfg_data  <= limit;
        @(posedge clk);
        cfg_index <= CFG_ARRIVE_TOL;
        cfg_data  <= tol;
        @(posedge clk);
        cfg_write <= 1'b0;
        settings_used++;
    endtask

    // One move: new goal, start, approach ticks, sometimes a full settling hold
    task automatic run_move(logic [CFG_W-1:0] tol);
        logic signed [POS_W-1:0] aim;
        longint                  offset;
        longint                  mag;
        int                      ticks;

        steady = ($urandom_range(0, 4) == 0);
        case ($urandom_range(0, 2))
            0:       aim = $urandom();
            1:       aim = $urandom_range(0, 2097152) - 1048576;
            default: aim = $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
        endcase
        if ($urandom_range(0, 2) == 0)
            stop_axis();
        set_goal(aim);
        if ($urandom_range(0, 3) == 0)
            tick(POS_W'(longint'(aim) - pick_offset()));
        start_axis();

        // approach: shrink the error, now and then jump or inject a stray request
        offset = pick_offset();
        ticks  = $urandom_range(8, 60);
        repeat (ticks)
        begin
            if ($urandom_range(0, 99) < 8)
                send_request(kind_t'(2'($urandom_range(0, 3))), $urandom(), $urandom());
            else
                tick(POS_W'(longint'(aim) - offset));
            if ($urandom_range(0, 99) < 15)
                offset = pick_offset();
            else
                offset = offset - offset / longint'($urandom_range(3, 12));
        end

        // settle: sometimes hold near the goal, mostly inside the tolerance and rarely just outside it
        if ($urandom_range(0, 3) == 0)
        begin
            ticks = $urandom_range(82, 100);
            repeat (ticks)
            begin
                case ($urandom_range(0, 9))
                    0:       mag = longint'(tol);
                    1:       mag = 0;
                    2:       mag = ($urandom_range(0, 9) == 0) ? longint'(tol) + 1
                                                               : longint'(tol);
                    default: mag = longint'($urandom_range(0, 32'(tol)));
                endcase
                tick(POS_W'(longint'(aim) - ($urandom_range(0, 1) ? mag : -mag)));
            end
        end
    endtask

    // Result side: stall at random, with steady stretches
    initial
    begin
        int stall;

        result_ch.ready = 1'b0;
        @(posedge clk);
        forever
        begin
            stall = pick_gap();
            if (stall > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    // End the run when nothing moves for too long
    always @(posedge clk)
    begin
        if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        logic [CFG_W-1:0] limit_plan [PHASES];
        logic [CFG_W-1:0] tol_plan [PHASES];
        int               phase_end;

        rst_n                   = 1'b0;
        cfg_write               = 1'b0;
        cfg_index               = CFG_SPEED_LIMIT;
        cfg_data                = '0;
        item_ch.valid           = 1'b0;
        item_ch.kind            = KIND_TICK;
        item_ch.position_sample = '0;
        item_ch.new_target      = '0;

        // settings: defaults, zeros, all ones, below-floor limit, exact max, random
        limit_plan = '{SPEED_LIMIT_RST, '0, '1, 21'd5000, SPEED_MAX,
                       CFG_W'($urandom_range(0, 2097151))};
        tol_plan   = '{ARRIVE_TOL_RST, '0, '1, 21'd1048576,
                       CFG_W'($urandom_range(0, 4000)), CFG_W'($urandom_range(0, 2097151))};

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // disabled ticks at the position extremes; the update period saturates
        tick(32'sh00000000);
        tick(32'sh7FFFFFFF);
        tick(32'sh80000000);
        repeat (7) tick($urandom());
        // goal at the negative extreme, stored while disabled
        set_goal(32'sh80000000);
        tick(32'sh00000000);
        start_axis();
        // huge error: the target is full speed, but the command rises by one slew step
        tick(32'sh7FFFFFFF);
        stop_axis();
        set_goal(32'sh7FFFFFFF);
        start_axis();
        tick(32'sh7FFFFFFF);
        set_goal(32'sh00000000);
        tick(-32'sd3277);
        tick(32'sd786432);
        stop_axis();

        // random moves under each register setting
        for (int p = 0; p < PHASES; p++)
        begin
            drain();
            apply_setting(limit_plan[p], tol_plan[p]);
            phase_end = requests_sent + REQUEST_TARGET / PHASES;
            while (requests_sent < phase_end)
                run_move(tol_plan[p]);
        end
        steady = 1'b0;
        drain();

        $display("Ran %0d requests under %0d register settings; %0d speed updates checked.",
                 requests_sent, settings_used, update_count);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

### files.f
rtl/pvp_pkg.sv
rtl/pvp_in_if.sv
rtl/pvp_out_if.sv
rtl/pvp_error_stage.sv
rtl/pvp_ctrl_stage.sv
rtl/axis_position_velocity_profiler.sv
test/pvp_profile_checker.sv
test/axis_position_velocity_profiler_test.sv
